// ===== rtl/pidpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pidpc_pkg;

    localparam int PosW     = 24;              // position and error width
    localparam int FracW    = 16;              // fraction bits of the gains
    localparam int GainW    = 32;
    localparam int LimW     = 23;              // cap and tolerance width
    localparam int DtW      = 16;
    localparam int IntW     = 48;              // integral width
    localparam int DiffW    = PosW + 1;        // error difference
    localparam int DivW     = DiffW + FracW;   // dividend magnitude width
    localparam int DivSteps = DivW;
    localparam int CntW     = 6;
    localparam int MulBW    = 25;              // multiplier b operand
    localparam int ChunkW   = 24;              // chunk of the wide operands
    localparam int ProdW    = GainW + MulBW;
    localparam int SumW     = 82;
    localparam int MacSteps = 5;
    localparam int OutW     = 32;
    localparam int CfgIdxW  = 3;
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;

    localparam logic [LimW-1:0] CapReset = 23'd480;
    localparam logic [LimW-1:0] TolReset = 23'd24;

    localparam logic [CfgIdxW-1:0] RegTarget = 3'd0;
    localparam logic [CfgIdxW-1:0] RegGainP  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegGainI  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegGainD  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegCap    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegTol    = 3'd5;

    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdClear  = 1'b1;

    localparam logic [2:0] MacP   = 3'd0;
    localparam logic [2:0] MacILo = 3'd1;
    localparam logic [2:0] MacIHi = 3'd2;
    localparam logic [2:0] MacDLo = 3'd3;
    localparam logic [2:0] MacDHi = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ERR  = 7'b0000010,
        ST_IMUL = 7'b0000100,
        ST_IADD = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_MAC  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       calc_err;
        logic       int_mul;
        logic       int_add;
        logic       div_step;
        logic       mac_load;
        logic       mac_add;
        logic [2:0] mac_idx;
        logic       finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_item;
        logic div_skip;
        logic out_free;
    } ctrl_status_t;

endpackage
`default_nettype wire

// ===== rtl/pidpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pidpc_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tuser,
    output logic                         s_tready,
    input  pidpc_pkg::ctrl_status_t      status,
    output pidpc_pkg::ctrl_cmd_t         cmd
);

    pidpc_pkg::state_t state_reg, state_next;
    logic [pidpc_pkg::CntW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pidpc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            pidpc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = (s_tuser == pidpc_pkg::CmdClear) ? pidpc_pkg::ST_FIN
                                                                  : pidpc_pkg::ST_ERR;
                end
            end
            pidpc_pkg::ST_ERR: begin
                cmd.calc_err = 1'b1;
                state_next   = pidpc_pkg::ST_IMUL;
            end
            pidpc_pkg::ST_IMUL: begin
                cmd.int_mul = 1'b1;
                state_next  = pidpc_pkg::ST_IADD;
            end
            pidpc_pkg::ST_IADD: begin
                cmd.int_add = 1'b1;
                cnt_next    = '0;
                state_next  = status.div_skip ? pidpc_pkg::ST_MAC : pidpc_pkg::ST_DIV;
            end
            pidpc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == pidpc_pkg::CntW'(pidpc_pkg::DivSteps - 1)) begin
                    cnt_next   = '0;
                    state_next = pidpc_pkg::ST_MAC;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pidpc_pkg::ST_MAC: begin
                // product of step n is added while step n+1 multiplies
                cmd.mac_load = (cnt_reg < pidpc_pkg::CntW'(pidpc_pkg::MacSteps));
                cmd.mac_add  = (cnt_reg != '0);
                cmd.mac_idx  = cnt_reg[2:0];
                if (cnt_reg == pidpc_pkg::CntW'(pidpc_pkg::MacSteps)) begin
                    state_next = pidpc_pkg::ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pidpc_pkg::ST_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = pidpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pidpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/pidpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pidpc_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  pidpc_pkg::ctrl_cmd_t                     cmd,
    output pidpc_pkg::ctrl_status_t                  status,
    input  wire logic [pidpc_pkg::InDataW-1:0]       s_tdata,
    input  wire logic                                s_tuser,
    input  wire logic                                cfg_valid,
    input  wire logic [pidpc_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire logic [pidpc_pkg::GainW-1:0]         cfg_data,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [pidpc_pkg::OutDataW-1:0]           m_tdata
);

    localparam int PosW  = pidpc_pkg::PosW;
    localparam int IntW  = pidpc_pkg::IntW;
    localparam int SumW  = pidpc_pkg::SumW;
    localparam int ProdW = pidpc_pkg::ProdW;
    localparam int DivW  = pidpc_pkg::DivW;

    // configuration
    logic signed [PosW-1:0]              target_reg;
    logic signed [pidpc_pkg::GainW-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [pidpc_pkg::LimW-1:0]          cap_reg, tol_reg;
    // controller state
    logic signed [IntW-1:0]              integ_reg;
    logic signed [PosW-1:0]              prev_reg;
    logic                                first_reg;
    // per item working registers
    logic                                clear_reg;
    logic signed [PosW-1:0]              pos_reg, e_reg;
    logic [pidpc_pkg::DtW-1:0]           dt_reg;
    logic signed [IntW-1:0]              acc_reg;
    logic                                sat_reg;
    logic [DivW-1:0]                     q_reg;
    logic [pidpc_pkg::DtW-1:0]           rem_reg;
    logic                                dneg_reg;
    logic signed [ProdW-1:0]             prod_reg;
    logic                                shift_reg;
    logic signed [SumW-1:0]              sum_reg;
    logic                                out_valid_reg;
    logic [pidpc_pkg::OutDataW-1:0]      out_data_reg;

    logic signed [PosW:0]                diff;
    logic signed [PosW-1:0]              ec;
    logic signed [pidpc_pkg::DiffW-1:0]  ediff;
    logic [pidpc_pkg::DiffW-1:0]         emag;
    logic signed [IntW:0]                acc_sum;
    logic [pidpc_pkg::DtW:0]             rem_sh, rem_sub;
    logic signed [IntW-1:0]              d_val;
    logic signed [pidpc_pkg::GainW-1:0]  mul_a;
    logic signed [pidpc_pkg::MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]             mul_p;
    logic signed [SumW-1:0]              addend;
    logic                                out_sat;
    logic [pidpc_pkg::OutW-1:0]          drive;
    logic signed [PosW-1:0]              prev_new;
    logic [PosW-1:0]                     prev_abs;
    logic                                fin_flag;
    logic                                div_skip;

    assign diff     = {target_reg[PosW-1], target_reg} - {pos_reg[PosW-1], pos_reg};
    assign ec       = (e_reg > $signed({1'b0, cap_reg})) ? $signed({1'b0, cap_reg}) : e_reg;
    assign ediff    = {e_reg[PosW-1], e_reg} - {prev_reg[PosW-1], prev_reg};
    assign emag     = ediff[pidpc_pkg::DiffW-1] ? -ediff : ediff;
    assign acc_sum  = {integ_reg[IntW-1], integ_reg} + prod_reg[IntW:0];
    assign div_skip = first_reg || (dt_reg == '0);

    assign rem_sh  = {rem_reg, q_reg[DivW-1]};
    assign rem_sub = rem_sh - {1'b0, dt_reg};

    // quotient is zero whenever the division was skipped
    always_comb begin
        d_val = $signed({{(IntW-DivW){1'b0}}, q_reg});
        if (dneg_reg) d_val = -d_val;
    end

    always_comb begin
        mul_a = gain_p_reg;
        mul_b = {e_reg[PosW-1], e_reg};
        if (cmd.int_mul) begin
            mul_a = $signed({{(pidpc_pkg::GainW-pidpc_pkg::DtW){1'b0}}, dt_reg});
            mul_b = {ec[PosW-1], ec};
        end else begin
            case (cmd.mac_idx)
                pidpc_pkg::MacP: begin
                    mul_a = gain_p_reg;
                    mul_b = {e_reg[PosW-1], e_reg};
                end
                pidpc_pkg::MacILo: begin
                    mul_a = gain_i_reg;
                    mul_b = {1'b0, acc_reg[23:0]};
                end
                pidpc_pkg::MacIHi: begin
                    mul_a = gain_i_reg;
                    mul_b = {acc_reg[IntW-1], acc_reg[IntW-1:24]};
                end
                pidpc_pkg::MacDLo: begin
                    mul_a = gain_d_reg;
                    mul_b = {1'b0, d_val[23:0]};
                end
                pidpc_pkg::MacDHi: begin
                    mul_a = gain_d_reg;
                    mul_b = {d_val[IntW-1], d_val[IntW-1:24]};
                end
                default: begin
                    mul_a = gain_p_reg;
                    mul_b = {e_reg[PosW-1], e_reg};
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        addend = {{(SumW-ProdW){prod_reg[ProdW-1]}}, prod_reg};
        if (shift_reg) addend = addend <<< pidpc_pkg::ChunkW;
    end

    // result is in range when all bits above the kept word match its sign
    assign out_sat = !((&sum_reg[SumW-1:pidpc_pkg::FracW+pidpc_pkg::OutW-1]) ||
                       (~|sum_reg[SumW-1:pidpc_pkg::FracW+pidpc_pkg::OutW-1]));
    always_comb begin
        drive = sum_reg[pidpc_pkg::FracW+pidpc_pkg::OutW-1:pidpc_pkg::FracW];
        if (out_sat) drive = sum_reg[SumW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end

    assign prev_new = clear_reg ? '0 : e_reg;
    assign prev_abs = prev_new[PosW-1] ? -prev_new : prev_new;
    assign fin_flag = prev_abs < {1'b0, tol_reg};

    assign status.clear_item = clear_reg;
    assign status.div_skip   = div_skip;
    assign status.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            cap_reg    <= pidpc_pkg::CapReset;
            tol_reg    <= pidpc_pkg::TolReset;
            integ_reg  <= '0;
            prev_reg   <= '0;
            first_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    pidpc_pkg::RegTarget: begin
                        target_reg <= cfg_data[PosW-1:0];
                        integ_reg  <= '0;
                        prev_reg   <= '0;
                        first_reg  <= 1'b1;
                    end
                    pidpc_pkg::RegGainP: gain_p_reg <= cfg_data;
                    pidpc_pkg::RegGainI: gain_i_reg <= cfg_data;
                    pidpc_pkg::RegGainD: gain_d_reg <= cfg_data;
                    pidpc_pkg::RegCap:   cap_reg    <= cfg_data[pidpc_pkg::LimW-1:0];
                    pidpc_pkg::RegTol:   tol_reg    <= cfg_data[pidpc_pkg::LimW-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                prev_reg      <= prev_new;
                if (clear_reg) begin
                    integ_reg <= '0;
                    first_reg <= 1'b1;
                end else begin
                    integ_reg <= acc_reg;
                    first_reg <= 1'b0;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            clear_reg <= s_tuser;
            pos_reg   <= s_tdata[PosW-1:0];
            dt_reg    <= s_tdata[PosW+pidpc_pkg::DtW-1:PosW];
            sat_reg   <= 1'b0;
        end
        if (cmd.calc_err) begin
            if (diff > $signed({2'b00, {(PosW-1){1'b1}}})) begin
                e_reg   <= {1'b0, {(PosW-1){1'b1}}};
                sat_reg <= 1'b1;
            end else if (diff < $signed({2'b11, {(PosW-1){1'b0}}})) begin
                e_reg   <= {1'b1, {(PosW-1){1'b0}}};
                sat_reg <= 1'b1;
            end else begin
                e_reg <= diff[PosW-1:0];
            end
        end
        if (cmd.int_mul || cmd.mac_load) begin
            prod_reg  <= mul_p;
            shift_reg <= cmd.mac_load &&
                         (cmd.mac_idx == pidpc_pkg::MacIHi || cmd.mac_idx == pidpc_pkg::MacDHi);
        end
        if (cmd.int_add) begin
            if (acc_sum[IntW] != acc_sum[IntW-1]) begin
                acc_reg <= {acc_sum[IntW], {(IntW-1){~acc_sum[IntW]}}};
                sat_reg <= 1'b1;
            end else begin
                acc_reg <= acc_sum[IntW-1:0];
            end
            sum_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= div_skip ? '0 : {emag, {pidpc_pkg::FracW{1'b0}}};
            dneg_reg <= ediff[pidpc_pkg::DiffW-1];
        end
        if (cmd.div_step) begin
            if (!rem_sub[pidpc_pkg::DtW]) begin
                rem_reg <= rem_sub[pidpc_pkg::DtW-1:0];
                q_reg   <= {q_reg[DivW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[pidpc_pkg::DtW-1:0];
                q_reg   <= {q_reg[DivW-2:0], 1'b0};
            end
        end
        if (cmd.mac_add) begin
            sum_reg <= sum_reg + addend;
        end
        if (cmd.finish) begin
            out_data_reg <= {6'b0,
                             !clear_reg && (sat_reg || out_sat),
                             fin_flag,
                             clear_reg ? '0 : drive};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== rtl/pid_position_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fixed-point position PID controller. One item at a time: an update item passes
// through control (accept, error, integral multiply, integral add, result), the
// bit-serial derivative divider and the multiply-accumulate steps on a shared
// 32x25 multiplier; the divider is skipped when the derivative is zero (first update
// after a reset, clear or target write, or zero step time); a clear item goes from
// accept straight to result. The result waits in an output register; the last
// step of an item stalls while an earlier result is still unaccepted, and the next
// item is accepted as soon as the controller is back in idle. Configuration writes
// are taken every cycle and are meant to be issued only while no item is in flight.
module pid_position_controller (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pidpc_pkg::InDataW-1:0]       s_tdata,  // measured_position, step_time
    input  wire logic                                s_tuser,  // cmd
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [pidpc_pkg::OutDataW-1:0]           m_tdata,  // drive_effort, finished, saturated
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pidpc_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire logic [pidpc_pkg::GainW-1:0]         cfg_data
);

    pidpc_pkg::ctrl_cmd_t    cmd;
    pidpc_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    pidpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pidpc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in flight");

    a_finish_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result written over a pending result");

    a_div_not_skipped: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !status.div_skip)
        else $error("divider running on a skipped derivative");

    a_clear_zero_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && status.clear_item) |=> (m_tdata[31:0] == '0 && !m_tdata[33]))
        else $error("clear item gave nonzero drive");
`endif

endmodule
`default_nettype wire
